### src/cdq_pkg.sv
// Shared constants, types and index helpers for the circular deque.
package cdq_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WORD_W = 32;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [1:0]               action_t;
  typedef logic [1:0]               status_t;

  localparam action_t ACT_PUSH_FRONT = 2'd0;
  localparam action_t ACT_PUSH_REAR  = 2'd1;
  localparam action_t ACT_POP_FRONT  = 2'd2;
  localparam action_t ACT_POP_REAR   = 2'd3;

  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_FULL_PUSH  = 2'd1;
  localparam status_t ST_EMPTY_POP  = 2'd2;

  typedef struct packed {
    status_t status;
    word_t   popped_value;
    logic    is_empty_now;
    logic    is_full_now;
    word_t   front_value;
    word_t   rear_value;
  } result_t;

  typedef struct packed {
    logic  we;
    idx_t  wr_addr;
    word_t wr_data;
    idx_t  rd_addr;
  } ram_req_t;

  function automatic idx_t idx_next(input idx_t i);
    return (i == IDX_W'(SLOTS - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_prev(input idx_t i);
    return (i == '0) ? IDX_W'(SLOTS - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

### src/cdq_if.sv
// Request and response channel interfaces of the circular deque.
interface cdq_req_if import cdq_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  word_t   push_value;

  modport source(output valid, action, push_value, input ready);
  modport sink(input valid, action, push_value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   popped_value;
  logic    is_empty_now;
  logic    is_full_now;
  word_t   front_value;
  word_t   rear_value;

  modport source(output valid, status, popped_value, is_empty_now, is_full_now,
                 front_value, rear_value, input ready);
  modport sink(input valid, status, popped_value, is_empty_now, is_full_now,
               front_value, rear_value, output ready);
endinterface

### src/cdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/cdq_ctrl.sv
// Deque control: end indices, cached end words and the pop read sequence.
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  action_t  req_action,
  input  word_t    req_push_value,
  output logic     req_ready,
  input  logic     slot_free,
  output logic     res_load,
  output result_t  res,
  output ram_req_t ram_req,
  input  word_t    rd_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic  state, state_next;
  idx_t  front_index, front_index_next;
  idx_t  rear_index, rear_index_next;
  word_t front_word, front_word_next;
  word_t rear_word, rear_word_next;
  word_t popped_word, popped_word_next;
  logic  pop_front, pop_front_next;
  idx_t  read_addr, read_addr_next;

  logic  empty_cur, full_cur, empty_after, full_after, accept;

  assign empty_cur   = (front_index == rear_index);
  assign full_cur    = (idx_next(rear_index) == front_index);
  assign empty_after = (front_index_next == rear_index_next);
  assign full_after  = (idx_next(rear_index_next) == front_index_next);

  // A successful pop only needs the result slot once its read data is back.
  // A pop on an empty deque answers at once, so it needs the slot straight away.
  assign req_ready = (state == S_IDLE) && (slot_free || (req_action[1] && !empty_cur));
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    rear_index_next  = rear_index;
    front_word_next  = front_word;
    rear_word_next   = rear_word;
    popped_word_next = popped_word;
    pop_front_next   = pop_front;
    read_addr_next   = read_addr;
    ram_req.we       = 1'b0;
    ram_req.wr_addr  = front_index;
    ram_req.wr_data  = req_push_value;
    ram_req.rd_addr  = read_addr;
    res_load         = 1'b0;
    res.status       = ST_DONE;
    res.popped_value = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_action)
            ACT_PUSH_FRONT: begin
              res_load = 1'b1;
              if (full_cur) begin
                res.status = ST_FULL_PUSH;
              end else begin
                ram_req.we       = 1'b1;
                ram_req.wr_addr  = front_index;
                front_index_next = idx_prev(front_index);
                front_word_next  = req_push_value;
                if (empty_cur) begin
                  rear_word_next = req_push_value;
                end
              end
            end
            ACT_PUSH_REAR: begin
              res_load = 1'b1;
              if (full_cur) begin
                res.status = ST_FULL_PUSH;
              end else begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = idx_next(rear_index);
                rear_index_next = idx_next(rear_index);
                rear_word_next  = req_push_value;
                if (empty_cur) begin
                  front_word_next = req_push_value;
                end
              end
            end
            ACT_POP_FRONT: begin
              if (empty_cur) begin
                res_load   = 1'b1;
                res.status = ST_EMPTY_POP;
              end else begin
                front_index_next = idx_next(front_index);
                popped_word_next = front_word;
                pop_front_next   = 1'b1;
                read_addr_next   = idx_next(idx_next(front_index));
                ram_req.rd_addr  = read_addr_next;
                state_next       = S_READ;
              end
            end
            default: begin
              if (empty_cur) begin
                res_load   = 1'b1;
                res.status = ST_EMPTY_POP;
              end else begin
                rear_index_next  = idx_prev(rear_index);
                popped_word_next = rear_word;
                pop_front_next   = 1'b0;
                read_addr_next   = idx_prev(rear_index);
                ram_req.rd_addr  = read_addr_next;
                state_next       = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // Read address is held, so the data stays put while the slot is busy.
        if (slot_free) begin
          res_load         = 1'b1;
          res.popped_value = popped_word;
          state_next       = S_IDLE;
          if (empty_cur) begin
            front_word_next = '0;
            rear_word_next  = '0;
          end else if (pop_front) begin
            front_word_next = rd_data;
          end else begin
            rear_word_next = rd_data;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.is_empty_now = empty_after;
    res.is_full_now  = full_after;
    res.front_value  = front_word_next;
    res.rear_value   = rear_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      rear_index  <= '0;
      front_word  <= '0;
      rear_word   <= '0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      front_word  <= front_word_next;
      rear_word   <= rear_word_next;
    end
    popped_word <= popped_word_next;
    pop_front   <= pop_front_next;
    read_addr   <= read_addr_next;
  end

endmodule

### src/circular_deque_top.sv
// Top level of the circular deque: ring memory, control and result register.
// A push or a rejected operation shows its result in the cycle after the item is
// accepted; a successful pop first waits on one registered read of the ring
// memory for the new end word and on a free result slot, then on the result register.
// One push per cycle while the result slot is free; a pop holds off new requests.
// Reset clears both end indices, the cached end words and the result valid flag.
module circular_deque_top import cdq_pkg::*; (
  input logic       clk,
  input logic       rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);

  // The result register parts the two sides: a new item can be taken in the
  // cycle its predecessor's result is being handed over.
  result_t  res;
  result_t  rsp_data;
  ram_req_t ram_req;
  word_t    rd_data;
  logic     res_load;
  logic     slot_free;
  logic     rsp_valid;

  assign slot_free = !rsp_valid || rsp.ready;

  cdq_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req.valid),
    .req_action     (req.action),
    .req_push_value (req.push_value),
    .req_ready      (req.ready),
    .slot_free      (slot_free),
    .res_load       (res_load),
    .res            (res),
    .ram_req        (ram_req),
    .rd_data        (rd_data)
  );

  // The ring itself. A pop reads the new end slot; unless the pop empties the deque,
  // that slot is occupied and was written by an earlier push, else its data is unused.
  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ring (
    .clk     (clk),
    .we      (ram_req.we),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  // Output register: loaded when the control hands over a finished result,
  // cleared once the downstream side has taken it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_load) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_data.status;
  assign rsp.popped_value = rsp_data.popped_value;
  assign rsp.is_empty_now = rsp_data.is_empty_now;
  assign rsp.is_full_now  = rsp_data.is_full_now;
  assign rsp.front_value  = rsp_data.front_value;
  assign rsp.rear_value   = rsp_data.rear_value;

endmodule

### src/cdq_checker.sv
// Port-level checks on the circular deque and their binding to the top level.
module cdq_checker import cdq_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input status_t status,
  input word_t   popped_value,
  input logic    is_empty_now,
  input logic    is_full_now,
  input word_t   front_value,
  input word_t   rear_value
);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(popped_value) && $stable(front_value) && $stable(rear_value))
    else $error("stalled result changed");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty_now |-> front_value == '0 && rear_value == '0)
    else $error("empty deque reports non-zero end values");

  a_not_empty_and_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(is_empty_now && is_full_now))
    else $error("deque reported empty and full at once");

  a_reject_pops_nothing: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_DONE |-> popped_value == '0)
    else $error("rejected operation returned a popped word");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .popped_value (rsp.popped_value),
  .is_empty_now (rsp.is_empty_now),
  .is_full_now  (rsp.is_full_now),
  .front_value  (rsp.front_value),
  .rear_value   (rsp.rear_value)
);
